>>> rtl/ggap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggap_pkg
// Shared types, character codes and small tables of the GGA sentence parser.
// ----------------------------------------------------------------------------
package ggap_pkg;

    // ASCII codes the front end reacts to
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SOUTH  = 8'h53;
    localparam logic [7:0] CH_WEST   = 8'h57;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field numbers (commas seen) of the GGA sentence
    localparam logic [4:0] FLD_TIME    = 5'd1;
    localparam logic [4:0] FLD_LAT     = 5'd2;
    localparam logic [4:0] FLD_NS      = 5'd3;
    localparam logic [4:0] FLD_LON     = 5'd4;
    localparam logic [4:0] FLD_EW      = 5'd5;
    localparam logic [4:0] FLD_FIX     = 5'd6;
    localparam logic [4:0] FLD_SATS    = 5'd7;
    localparam logic [4:0] FLD_HDOP    = 5'd8;
    localparam logic [4:0] FLD_ALT     = 5'd9;
    localparam logic [4:0] FLD_GEOID   = 5'd11;
    localparam logic [4:0] FLD_AGE     = 5'd13;
    localparam logic [4:0] FLD_STATION = 5'd14;
    localparam logic [4:0] FLD_MAX     = 5'd31;

    localparam logic [3:0] NAME_LEN = 4'd5;
    localparam logic [3:0] POS_MAX  = 4'd15;

    // Reciprocals floor(2^32 / d) for divide by constant with one correction
    localparam logic [63:0] RECIP_1E7 = 64'd429;
    localparam logic [63:0] RECIP_1E5 = 64'd42949;
    localparam logic [63:0] RECIP_1E3 = 64'd4294967;
    localparam logic [63:0] RECIP_6   = 64'd715827882;

    // Width of the output record word; back end packs its fields from the lowest bit up
    localparam int OUT_W = 192;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_END    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [4:0]  field;
        logic [31:0] acc;
        logic [2:0]  frac;
        logic        neg;
        logic        empty;
    } cmd_t;

    // Fraction digits kept per field
    function automatic logic [2:0] keep_frac(input logic [4:0] fld);
        logic [2:0] k;
        case (fld)
            5'd1:    k = 3'd3;
            5'd2:    k = 3'd5;
            5'd4:    k = 3'd5;
            5'd8:    k = 3'd2;
            5'd9:    k = 3'd2;
            5'd11:   k = 3'd2;
            5'd13:   k = 3'd2;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    // Expected sentence name "GPGGA"
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h47;
            4'd1:    ch = 8'h50;
            4'd2:    ch = 8'h47;
            4'd3:    ch = 8'h47;
            4'd4:    ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [16:0] pow10(input logic [2:0] k);
        logic [16:0] p;
        case (k)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

>>> rtl/nmea_gga_sentence_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// NMEA 0183 GGA sentence parser: one character in, one record word out per
// completed GPGGA sentence.
// ----------------------------------------------------------------------------
// The parser takes one character per clock. The front end frames sentences,
// checks the name and accumulates each field; every field end becomes a
// command in a QUEUE_DEPTH entry queue, which the back end drains at one
// command per clock while no output word waits, through a six-stage pipeline
// (scaling, reciprocal divides, degree and time assembly, record update).
// The record word of the sentence closed by '*', CR or LF passes the stage
// registers into an output register and waits there; the input stalls only
// when that word is not taken and the queue has filled behind it.
module nmea_gga_sentence_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,   // data_byte
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // time_of_day_ms, latitude_e7, longitude_e7, fix_quality, satellites_used,
    // hdop_centi, altitude_centi, geoid_sep_centi, diff_age_centi, station_id
    output logic [ggap_pkg::OUT_W-1:0]      m_axis_tdata
);

    ggap_pkg::cmd_t front_cmd, head_cmd;
    logic           front_valid, q_not_empty, q_full, q_pop, byte_take;

    assign s_axis_tready = !q_full;
    assign byte_take     = s_axis_tvalid && !q_full;

    ggap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_take),
        .data_byte (s_axis_tdata),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    ggap_cmdq #(
        .DEPTH(QUEUE_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .not_empty(q_not_empty),
        .full     (q_full)
    );

    ggap_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (head_cmd),
        .cmd_valid(q_not_empty),
        .cmd_pop  (q_pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/ggap_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggap_front
// Character front end: sentence framing, name match, field split and
// decimal accumulation. Emits one command per field end or sentence event.
// ----------------------------------------------------------------------------
module ggap_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    data_byte,
    output ggap_pkg::cmd_t     cmd,
    output logic               cmd_valid
);

    logic        in_sent_reg, in_sent_next;
    logic        name_ok_reg, name_ok_next;
    logic [3:0]  pos_reg, pos_next;
    logic [4:0]  fld_reg, fld_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  frac_reg, frac_next;

    logic        is_digit;
    logic [35:0] acc_mul;
    logic [31:0] acc_sat;
    logic [2:0]  keep;

    assign is_digit = (data_byte >= ggap_pkg::CH_ZERO) && (data_byte <= ggap_pkg::CH_NINE);
    assign acc_mul  = {4'b0, acc_reg} * 36'd10 + 36'(data_byte - ggap_pkg::CH_ZERO);
    assign acc_sat  = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_mul[31:0];
    assign keep     = ggap_pkg::keep_frac(fld_reg);

    // Command snapshot of the field being closed
    always_comb
    begin
        cmd.kind  = ggap_pkg::CMD_COMMIT;
        cmd.field = fld_reg;
        cmd.acc   = acc_reg;
        cmd.frac  = frac_reg;
        cmd.neg   = neg_reg;
        cmd.empty = (pos_reg == 4'd0);
        cmd_valid = 1'b0;

        in_sent_next = in_sent_reg;
        name_ok_next = name_ok_reg;
        pos_next     = pos_reg;
        fld_next     = fld_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        frac_next    = frac_reg;

        if (byte_valid)
        begin
            if (data_byte == ggap_pkg::CH_DOLLAR)
            begin
                cmd.kind     = ggap_pkg::CMD_CLEAR;
                cmd_valid    = 1'b1;
                in_sent_next = 1'b1;
                name_ok_next = 1'b1;
                fld_next     = 5'd0;
                pos_next     = 4'd0;
                neg_next     = 1'b0;
                acc_next     = 32'd0;
                frac_next    = 3'd0;
            end
            else if (in_sent_reg)
            begin
                if (data_byte == ggap_pkg::CH_STAR || data_byte == ggap_pkg::CH_CR ||
                    data_byte == ggap_pkg::CH_LF)
                begin
                    in_sent_next = 1'b0;
                    cmd.kind     = ggap_pkg::CMD_END;
                    cmd_valid    = name_ok_reg && (fld_reg != 5'd0);
                end
                else if (fld_reg == 5'd0)
                begin
                    // Sentence name
                    if (data_byte == ggap_pkg::CH_COMMA)
                    begin
                        if (pos_reg != ggap_pkg::NAME_LEN)
                            name_ok_next = 1'b0;
                        fld_next  = 5'd1;
                        pos_next  = 4'd0;
                        neg_next  = 1'b0;
                        acc_next  = 32'd0;
                        frac_next = 3'd0;
                    end
                    else
                    begin
                        if (pos_reg >= ggap_pkg::NAME_LEN ||
                            data_byte != ggap_pkg::name_char(pos_reg))
                            name_ok_next = 1'b0;
                        if (pos_reg != ggap_pkg::POS_MAX)
                            pos_next = pos_reg + 4'd1;
                    end
                end
                else if (name_ok_reg)
                begin
                    if (data_byte == ggap_pkg::CH_COMMA)
                    begin
                        cmd_valid = 1'b1;
                        if (fld_reg != ggap_pkg::FLD_MAX)
                            fld_next = fld_reg + 5'd1;
                        pos_next  = 4'd0;
                        neg_next  = 1'b0;
                        acc_next  = 32'd0;
                        frac_next = 3'd0;
                    end
                    else
                    begin
                        if (pos_reg != ggap_pkg::POS_MAX)
                            pos_next = pos_reg + 4'd1;
                        if (is_digit)
                        begin
                            if (frac_reg == 3'd0)
                                acc_next = acc_sat;
                            else if ((frac_reg - 3'd1) < keep)
                            begin
                                acc_next  = acc_sat;
                                frac_next = frac_reg + 3'd1;
                            end
                        end
                        else if (data_byte == ggap_pkg::CH_DOT)
                        begin
                            if (frac_reg == 3'd0)
                                frac_next = 3'd1;
                        end
                        else if (fld_reg == ggap_pkg::FLD_NS)
                        begin
                            if (data_byte == ggap_pkg::CH_SOUTH)
                                neg_next = 1'b1;
                        end
                        else if (fld_reg == ggap_pkg::FLD_EW)
                        begin
                            if (data_byte == ggap_pkg::CH_WEST)
                                neg_next = 1'b1;
                        end
                        else if (data_byte == ggap_pkg::CH_MINUS)
                            neg_next = 1'b1;
                    end
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg <= 1'b0;
            name_ok_reg <= 1'b0;
            pos_reg     <= 4'd0;
            fld_reg     <= 5'd0;
            neg_reg     <= 1'b0;
            acc_reg     <= 32'd0;
            frac_reg    <= 3'd0;
        end
        else
        begin
            in_sent_reg <= in_sent_next;
            name_ok_reg <= name_ok_next;
            pos_reg     <= pos_next;
            fld_reg     <= fld_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
        end
    end

    // Kept fraction digits never exceed the field's limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (frac_reg != 3'd0) |-> ((frac_reg - 3'd1) <= ggap_pkg::keep_frac(fld_reg)))
        else $error("fraction count beyond kept digits");

    // Outside a sentence no command leaves except a sentence start
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !in_sent_reg) |-> (cmd.kind == ggap_pkg::CMD_CLEAR))
        else $error("command outside a sentence");

    // A field command only follows a matched name
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.kind != ggap_pkg::CMD_CLEAR) |-> (name_ok_reg && fld_reg != 5'd0))
        else $error("field command without name match");

endmodule
`default_nettype wire

>>> rtl/ggap_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggap_cmdq
// Short command queue between the character front end and the record back end.
// ----------------------------------------------------------------------------
module ggap_cmdq #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  ggap_pkg::cmd_t      push_cmd,
    input  wire logic           pop,
    output ggap_pkg::cmd_t      head_cmd,
    output logic                not_empty,
    output logic                full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ggap_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> full)
        else $error("full queue lost its fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not drain the queue");

endmodule
`default_nettype wire

>>> rtl/ggap_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggap_back
// Record back end: scales each field, converts time and degree-minutes with
// reciprocal multiplies, stores the record and loads the output register.
// ----------------------------------------------------------------------------
module ggap_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  ggap_pkg::cmd_t                  cmd,
    input  wire logic                       cmd_valid,
    output logic                            cmd_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ggap_pkg::OUT_W-1:0]      out_data
);

    logic adv;

    // Stage 1: scale by missing fraction digits
    logic                s1_valid_reg;
    ggap_pkg::cmd_kind_t s1_kind_reg;
    logic [4:0]          s1_fld_reg;
    logic                s1_neg_reg, s1_empty_reg;
    logic [31:0]         s1_v_reg;
    // Stage 2: quotient estimates
    logic                s2_valid_reg;
    ggap_pkg::cmd_kind_t s2_kind_reg;
    logic [4:0]          s2_fld_reg;
    logic                s2_neg_reg, s2_empty_reg;
    logic [31:0]         s2_v_reg;
    logic [8:0]          s2_qa_reg;
    logic [15:0]         s2_qb_reg;
    logic [22:0]         s2_qc_reg;
    // Stage 3: corrected quotients
    logic                s3_valid_reg;
    ggap_pkg::cmd_kind_t s3_kind_reg;
    logic [4:0]          s3_fld_reg;
    logic                s3_neg_reg, s3_empty_reg;
    logic [31:0]         s3_v_reg;
    logic [8:0]          s3_a_reg;
    logic [23:0]         s3_mins_reg;
    logic [15:0]         s3_b_reg;
    logic [22:0]         s3_c_reg;
    logic [9:0]          s3_ms_reg;
    // Stage 4: minute division estimate and time digits
    logic                s4_valid_reg;
    ggap_pkg::cmd_kind_t s4_kind_reg;
    logic [4:0]          s4_fld_reg;
    logic                s4_neg_reg, s4_empty_reg;
    logic [31:0]         s4_v_reg;
    logic [8:0]          s4_a_reg;
    logic [26:0]         s4_y_reg;
    logic [23:0]         s4_q6_reg;
    logic [6:0]          s4_mm_reg, s4_ss_reg;
    logic [9:0]          s4_ms_reg;
    // Stage 5: time sum and degree sum
    logic                s5_valid_reg;
    ggap_pkg::cmd_kind_t s5_kind_reg;
    logic [4:0]          s5_fld_reg;
    logic                s5_neg_reg, s5_empty_reg;
    logic [31:0]         s5_v_reg;
    logic [31:0]         s5_t_reg;
    logic [32:0]         s5_deg_reg;

    // Record
    logic [26:0] rec_time_reg, rec_time_next;
    logic [30:0] rec_lat_reg, rec_lat_next;
    logic [31:0] rec_lon_reg, rec_lon_next;
    logic [3:0]  rec_fix_reg, rec_fix_next;
    logic [6:0]  rec_sats_reg, rec_sats_next;
    logic [13:0] rec_hdop_reg, rec_hdop_next;
    logic [24:0] rec_alt_reg, rec_alt_next;
    logic [24:0] rec_geoid_reg, rec_geoid_next;
    logic [16:0] rec_age_reg, rec_age_next;
    logic [9:0]  rec_stn_reg, rec_stn_next;

    logic                       out_valid_reg;
    logic [ggap_pkg::OUT_W-1:0] out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign cmd_pop   = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stage 1 logic
    logic [2:0]  have, want, shift_k;
    logic [48:0] scaled;
    assign have    = (cmd.frac == 3'd0) ? 3'd0 : cmd.frac - 3'd1;
    assign want    = ggap_pkg::keep_frac(cmd.field);
    assign shift_k = (have < want) ? want - have : 3'd0;
    assign scaled  = 49'(cmd.acc) * 49'(ggap_pkg::pow10(shift_k));

    // Stage 2 logic
    logic [63:0] prod_a, prod_b, prod_c;
    assign prod_a = 64'(s1_v_reg) * ggap_pkg::RECIP_1E7;
    assign prod_b = 64'(s1_v_reg) * ggap_pkg::RECIP_1E5;
    assign prod_c = 64'(s1_v_reg) * ggap_pkg::RECIP_1E3;

    // Stage 3 logic
    logic [31:0] ra, rb, rc;
    logic        fix_a, fix_b, fix_c;
    assign ra    = s2_v_reg - 32'(s2_qa_reg) * 32'd10000000;
    assign rb    = s2_v_reg - 32'(s2_qb_reg) * 32'd100000;
    assign rc    = s2_v_reg - 32'(s2_qc_reg) * 32'd1000;
    assign fix_a = (ra >= 32'd10000000);
    assign fix_b = (rb >= 32'd100000);
    assign fix_c = (rc >= 32'd1000);

    // Stage 4 logic
    logic [26:0] y_val;
    logic [63:0] prod_6;
    logic [15:0] mm_full;
    logic [22:0] ss_full;
    assign y_val   = 27'(s3_mins_reg) * 27'd10 + 27'd3;
    assign prod_6  = 64'(y_val) * ggap_pkg::RECIP_6;
    assign mm_full = s3_b_reg - 16'(s3_a_reg) * 16'd100;
    assign ss_full = s3_c_reg - 23'(s3_b_reg) * 23'd100;

    // Stage 5 logic
    logic [26:0] r6;
    logic [23:0] q6;
    assign r6 = s4_y_reg - 27'(s4_q6_reg) * 27'd6;
    assign q6 = s4_q6_reg + ((r6 >= 27'd6) ? 24'd1 : 24'd0);

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg  <= cmd.kind;
            s1_fld_reg   <= cmd.field;
            s1_neg_reg   <= cmd.neg;
            s1_empty_reg <= cmd.empty;
            s1_v_reg     <= (scaled[48:32] != 17'd0) ? 32'hFFFF_FFFF : scaled[31:0];

            s2_kind_reg  <= s1_kind_reg;
            s2_fld_reg   <= s1_fld_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_empty_reg <= s1_empty_reg;
            s2_v_reg     <= s1_v_reg;
            s2_qa_reg    <= prod_a[40:32];
            s2_qb_reg    <= prod_b[47:32];
            s2_qc_reg    <= prod_c[54:32];

            s3_kind_reg  <= s2_kind_reg;
            s3_fld_reg   <= s2_fld_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_empty_reg <= s2_empty_reg;
            s3_v_reg     <= s2_v_reg;
            s3_a_reg     <= s2_qa_reg + (fix_a ? 9'd1 : 9'd0);
            s3_mins_reg  <= fix_a ? 24'(ra - 32'd10000000) : ra[23:0];
            s3_b_reg     <= s2_qb_reg + (fix_b ? 16'd1 : 16'd0);
            s3_c_reg     <= s2_qc_reg + (fix_c ? 23'd1 : 23'd0);
            s3_ms_reg    <= fix_c ? 10'(rc - 32'd1000) : rc[9:0];

            s4_kind_reg  <= s3_kind_reg;
            s4_fld_reg   <= s3_fld_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_empty_reg <= s3_empty_reg;
            s4_v_reg     <= s3_v_reg;
            s4_a_reg     <= s3_a_reg;
            s4_y_reg     <= y_val;
            s4_q6_reg    <= prod_6[55:32];
            s4_mm_reg    <= mm_full[6:0];
            s4_ss_reg    <= ss_full[6:0];
            s4_ms_reg    <= s3_ms_reg;

            s5_kind_reg  <= s4_kind_reg;
            s5_fld_reg   <= s4_fld_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_empty_reg <= s4_empty_reg;
            s5_v_reg     <= s4_v_reg;
            s5_t_reg     <= 32'(s4_a_reg) * 32'd3600000 + 32'(s4_mm_reg) * 32'd60000
                          + 32'(s4_ss_reg) * 32'd1000 + 32'(s4_ms_reg);
            s5_deg_reg   <= 33'(s4_a_reg) * 33'd10000000 + 33'(q6);
        end
    end

    // Stage 6: field values and record update
    logic [23:0] mag;
    logic [24:0] smag;
    assign mag  = (s5_v_reg > 32'd9999999) ? 24'd9999999 : s5_v_reg[23:0];
    assign smag = s5_neg_reg ? 25'(-{1'b0, mag}) : {1'b0, mag};

    always_comb
    begin
        rec_time_next  = rec_time_reg;
        rec_lat_next   = rec_lat_reg;
        rec_lon_next   = rec_lon_reg;
        rec_fix_next   = rec_fix_reg;
        rec_sats_next  = rec_sats_reg;
        rec_hdop_next  = rec_hdop_reg;
        rec_alt_next   = rec_alt_reg;
        rec_geoid_next = rec_geoid_reg;
        rec_age_next   = rec_age_reg;
        rec_stn_next   = rec_stn_reg;
        if (s5_valid_reg)
        begin
            if (s5_kind_reg == ggap_pkg::CMD_CLEAR)
            begin
                rec_time_next  = '0;
                rec_lat_next   = '0;
                rec_lon_next   = '0;
                rec_fix_next   = '0;
                rec_sats_next  = '0;
                rec_hdop_next  = '0;
                rec_alt_next   = '0;
                rec_geoid_next = '0;
                rec_age_next   = '0;
                rec_stn_next   = '0;
            end
            else
            begin
                case (s5_fld_reg)
                    ggap_pkg::FLD_TIME:
                        rec_time_next = (s5_v_reg >= 32'd240000000 ||
                                         s5_t_reg > 32'd86399999) ?
                                        27'd86399999 : s5_t_reg[26:0];
                    ggap_pkg::FLD_LAT:
                        rec_lat_next = (s5_v_reg >= 32'd910000000 ||
                                        s5_deg_reg > 33'd900000000) ?
                                       31'd900000000 : s5_deg_reg[30:0];
                    ggap_pkg::FLD_NS:
                        if (s5_empty_reg)
                            rec_lat_next = '0;
                        else if (s5_neg_reg)
                            rec_lat_next = -rec_lat_reg;
                    ggap_pkg::FLD_LON:
                        rec_lon_next = (s5_v_reg >= 32'd1810000000 ||
                                        s5_deg_reg > 33'd1800000000) ?
                                       32'd1800000000 : s5_deg_reg[31:0];
                    ggap_pkg::FLD_EW:
                        if (s5_empty_reg)
                            rec_lon_next = '0;
                        else if (s5_neg_reg)
                            rec_lon_next = -rec_lon_reg;
                    ggap_pkg::FLD_FIX:
                        rec_fix_next = (s5_v_reg > 32'd8) ? 4'd8 : s5_v_reg[3:0];
                    ggap_pkg::FLD_SATS:
                        rec_sats_next = (s5_v_reg > 32'd99) ? 7'd99 : s5_v_reg[6:0];
                    ggap_pkg::FLD_HDOP:
                        rec_hdop_next = (s5_v_reg > 32'd9999) ? 14'd9999 : s5_v_reg[13:0];
                    ggap_pkg::FLD_ALT:
                        rec_alt_next = smag;
                    ggap_pkg::FLD_GEOID:
                        rec_geoid_next = smag;
                    ggap_pkg::FLD_AGE:
                        rec_age_next = (s5_v_reg > 32'd99999) ? 17'd99999 : s5_v_reg[16:0];
                    ggap_pkg::FLD_STATION:
                        rec_stn_next = (s5_v_reg > 32'd1023) ? 10'd1023 : s5_v_reg[9:0];
                    default:
                        rec_time_next = rec_time_reg;
                endcase
                // Position not reached at sentence end reads as zero
                if (s5_kind_reg == ggap_pkg::CMD_END)
                begin
                    if (s5_fld_reg < ggap_pkg::FLD_NS)
                        rec_lat_next = '0;
                    if (s5_fld_reg < ggap_pkg::FLD_EW)
                        rec_lon_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec_time_reg  <= rec_time_next;
            rec_lat_reg   <= rec_lat_next;
            rec_lon_reg   <= rec_lon_next;
            rec_fix_reg   <= rec_fix_next;
            rec_sats_reg  <= rec_sats_next;
            rec_hdop_reg  <= rec_hdop_next;
            rec_alt_reg   <= rec_alt_next;
            rec_geoid_reg <= rec_geoid_next;
            rec_age_reg   <= rec_age_next;
            rec_stn_reg   <= rec_stn_next;
        end
        if (adv && s5_valid_reg && s5_kind_reg == ggap_pkg::CMD_END)
            out_data_reg <= {rec_stn_next, rec_age_next, rec_geoid_next, rec_alt_next,
                             rec_hdop_next, rec_sats_next, rec_fix_next, rec_lon_next,
                             rec_lat_next, rec_time_next};
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && s5_valid_reg && s5_kind_reg == ggap_pkg::CMD_END)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // A new record word only comes from a sentence end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(s5_valid_reg) &&
                                  $past(s5_kind_reg) == ggap_pkg::CMD_END))
        else $error("record word without sentence end");

    // Pipeline holds while the output word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && s5_valid_reg) |=> (s5_valid_reg && $stable(s5_fld_reg)))
        else $error("pipeline moved under stall");

    // A sentence start clears the stored record
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s5_valid_reg && s5_kind_reg == ggap_pkg::CMD_CLEAR) |=>
        (rec_time_reg == '0 && rec_lat_reg == '0 && rec_lon_reg == '0))
        else $error("record not cleared");

endmodule
`default_nettype wire

>>> dv/nmea_gga_sentence_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_test
// Self-checking bench for the GGA sentence parser. Character words are
// streamed in, each is run through a behavioral model of the parser, and
// every record word leaving the block is checked field by field against the
// oldest predicted record. Directed sentences cover the edge cases; random
// sentences and noise run under several idle/stall mixes and one long hold.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_test;

    // Record word, first field in the lowest bits
    typedef struct packed {
        logic [9:0]  station_id;
        logic [16:0] diff_age_centi;
        logic [24:0] geoid_sep_centi;
        logic [24:0] altitude_centi;
        logic [13:0] hdop_centi;
        logic [6:0]  satellites_used;
        logic [3:0]  fix_quality;
        logic [31:0] longitude_e7;
        logic [30:0] latitude_e7;
        logic [26:0] time_of_day_ms;
    } gga_record_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;   // data_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ggap_pkg::OUT_W-1:0] m_axis_tdata;   // record fields, see gga_record_t

    // Idle mix: sender idle percent, receiver stall percent
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 words_sent = 0;
    int                 records_seen = 0;
    int                 errors = 0;
    gga_record_t        pending_records[$];

    // Model state
    logic               framing_open;
    logic               talker_ok;
    logic [3:0]         char_count;
    logic [4:0]         comma_count;
    logic               minus_seen;
    logic [31:0]        accum;
    logic [2:0]         frac_state;
    logic [31:0]        rec[10];

    always #1 clk = ~clk;

    nmea_gga_sentence_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Behavioral parser model
    // ------------------------------------------------------------------------
    function automatic int frac_keep(input logic [4:0] f);
        case (f)
            ggap_pkg::FLD_TIME:                     return 3;
            ggap_pkg::FLD_LAT, ggap_pkg::FLD_LON:   return 5;
            ggap_pkg::FLD_HDOP, ggap_pkg::FLD_ALT,
            ggap_pkg::FLD_GEOID, ggap_pkg::FLD_AGE: return 2;
            default:                                return 0;
        endcase
    endfunction

    function automatic logic [63:0] sat64(input logic [63:0] v, input logic [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [31:0] to_degrees(input logic [63:0] v, input logic [63:0] lim);
        logic [63:0] deg;
        logic [63:0] mins;
        deg  = v / 64'd10000000;
        mins = v % 64'd10000000;
        return 32'(sat64(deg * 64'd10000000 + (mins * 64'd10 + 64'd3) / 64'd6, lim));
    endfunction

    function automatic logic [31:0] signed_centi(input logic [63:0] v);
        logic [31:0] m;
        m = 32'(sat64(v, 64'd9999999));
        return minus_seen ? 32'd0 - m : m;
    endfunction

    function automatic void clear_field();
        accum      = '0;
        frac_state = '0;
        minus_seen = 1'b0;
        char_count = '0;
    endfunction

    function automatic void commit_field();
        logic [63:0] v;
        int have;
        have = (frac_state != 0) ? int'(frac_state) - 1 : 0;
        v = 64'(accum);
        while (have < frac_keep(comma_count)) begin
            v = v * 10;
            have++;
        end
        case (comma_count)
            ggap_pkg::FLD_TIME:
                rec[0] = 32'(sat64((v / 64'd10000000) * 64'd3600000
                                   + ((v / 64'd100000) % 100) * 64'd60000
                                   + ((v / 64'd1000) % 100) * 64'd1000
                                   + v % 64'd1000, 64'd86399999));
            ggap_pkg::FLD_LAT:  rec[1] = to_degrees(v, 64'd900000000);
            ggap_pkg::FLD_NS:   if (char_count == 0) rec[1] = '0;
                                else if (minus_seen) rec[1] = 32'd0 - rec[1];
            ggap_pkg::FLD_LON:  rec[2] = to_degrees(v, 64'd1800000000);
            ggap_pkg::FLD_EW:   if (char_count == 0) rec[2] = '0;
                                else if (minus_seen) rec[2] = 32'd0 - rec[2];
            ggap_pkg::FLD_FIX:     rec[3] = 32'(sat64(v, 64'd8));
            ggap_pkg::FLD_SATS:    rec[4] = 32'(sat64(v, 64'd99));
            ggap_pkg::FLD_HDOP:    rec[5] = 32'(sat64(v, 64'd9999));
            ggap_pkg::FLD_ALT:     rec[6] = signed_centi(v);
            ggap_pkg::FLD_GEOID:   rec[7] = signed_centi(v);
            ggap_pkg::FLD_AGE:     rec[8] = 32'(sat64(v, 64'd99999));
            ggap_pkg::FLD_STATION: rec[9] = 32'(sat64(v, 64'd1023));
            default: ;
        endcase
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [63:0] next;
        gga_record_t r;
        if (c == ggap_pkg::CH_DOLLAR) begin
            framing_open = 1'b1;
            talker_ok    = 1'b1;
            comma_count  = '0;
            clear_field();
            foreach (rec[i]) rec[i] = '0;
            return;
        end
        if (!framing_open) return;
        if (c == ggap_pkg::CH_STAR || c == ggap_pkg::CH_CR || c == ggap_pkg::CH_LF) begin
            framing_open = 1'b0;
            if (!talker_ok || comma_count == 0) return;
            commit_field();
            if (comma_count < 3) rec[1] = '0;
            if (comma_count < 5) rec[2] = '0;
            r.time_of_day_ms  = rec[0][26:0];
            r.latitude_e7     = rec[1][30:0];
            r.longitude_e7    = rec[2];
            r.fix_quality     = rec[3][3:0];
            r.satellites_used = rec[4][6:0];
            r.hdop_centi      = rec[5][13:0];
            r.altitude_centi  = rec[6][24:0];
            r.geoid_sep_centi = rec[7][24:0];
            r.diff_age_centi  = rec[8][16:0];
            r.station_id      = rec[9][9:0];
            pending_records.push_back(r);
            return;
        end
        // name field
        if (comma_count == 0) begin
            if (c == ggap_pkg::CH_COMMA) begin
                if (char_count != ggap_pkg::NAME_LEN) talker_ok = 1'b0;
                comma_count = 5'd1;
                clear_field();
            end else begin
                if (char_count >= ggap_pkg::NAME_LEN || c != ggap_pkg::name_char(char_count))
                    talker_ok = 1'b0;
                if (char_count < ggap_pkg::POS_MAX) char_count++;
            end
            return;
        end
        if (!talker_ok) return;
        if (c == ggap_pkg::CH_COMMA) begin
            commit_field();
            if (comma_count < ggap_pkg::FLD_MAX) comma_count++;
            clear_field();
            return;
        end
        if (char_count < ggap_pkg::POS_MAX) char_count++;
        if (c >= ggap_pkg::CH_ZERO && c <= ggap_pkg::CH_NINE) begin
            next = 64'(accum) * 10 + 64'(c - ggap_pkg::CH_ZERO);
            if (frac_state == 0) begin
                accum = 32'(sat64(next, 64'hFFFFFFFF));
            end else if (int'(frac_state) - 1 < frac_keep(comma_count)) begin
                accum = 32'(sat64(next, 64'hFFFFFFFF));
                frac_state++;
            end
        end else if (c == ggap_pkg::CH_DOT) begin
            if (frac_state == 0) frac_state = 3'd1;
        end else if (comma_count == ggap_pkg::FLD_NS) begin
            if (c == ggap_pkg::CH_SOUTH) minus_seen = 1'b1;
        end else if (comma_count == ggap_pkg::FLD_EW) begin
            if (c == ggap_pkg::CH_WEST) minus_seen = 1'b1;
        end else if (c == ggap_pkg::CH_MINUS) begin
            minus_seen = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one character word per call, random idle cycles first
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        parse_char(c);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus long holds on request
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Record checker
    always @(posedge clk) begin
        gga_record_t got;
        gga_record_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = gga_record_t'(m_axis_tdata);
            records_seen++;
            if (pending_records.size() == 0) begin
                $error("record word with no prediction pending: %h", m_axis_tdata);
                errors++;
            end
            else begin
                want = pending_records.pop_front();
                if (got.time_of_day_ms !== want.time_of_day_ms) begin
                    $error("time_of_day_ms exp %0d got %0d",
                           want.time_of_day_ms, got.time_of_day_ms);
                    errors++;
                end
                if (got.latitude_e7 !== want.latitude_e7) begin
                    $error("latitude_e7 exp %0d got %0d",
                           $signed(want.latitude_e7), $signed(got.latitude_e7));
                    errors++;
                end
                if (got.longitude_e7 !== want.longitude_e7) begin
                    $error("longitude_e7 exp %0d got %0d",
                           $signed(want.longitude_e7), $signed(got.longitude_e7));
                    errors++;
                end
                if (got.fix_quality !== want.fix_quality) begin
                    $error("fix_quality exp %0d got %0d", want.fix_quality, got.fix_quality);
                    errors++;
                end
                if (got.satellites_used !== want.satellites_used) begin
                    $error("satellites_used exp %0d got %0d",
                           want.satellites_used, got.satellites_used);
                    errors++;
                end
                if (got.hdop_centi !== want.hdop_centi) begin
                    $error("hdop_centi exp %0d got %0d", want.hdop_centi, got.hdop_centi);
                    errors++;
                end
                if (got.altitude_centi !== want.altitude_centi) begin
                    $error("altitude_centi exp %0d got %0d",
                           $signed(want.altitude_centi), $signed(got.altitude_centi));
                    errors++;
                end
                if (got.geoid_sep_centi !== want.geoid_sep_centi) begin
                    $error("geoid_sep_centi exp %0d got %0d",
                           $signed(want.geoid_sep_centi), $signed(got.geoid_sep_centi));
                    errors++;
                end
                if (got.diff_age_centi !== want.diff_age_centi) begin
                    $error("diff_age_centi exp %0d got %0d",
                           want.diff_age_centi, got.diff_age_centi);
                    errors++;
                end
                if (got.station_id !== want.station_id) begin
                    $error("station_id exp %0d got %0d", want.station_id, got.station_id);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random sentence pieces
    // ------------------------------------------------------------------------
    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(ggap_pkg::CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_number(input int int_max, input int frac_max);
        string s;
        s = "";
        if ($urandom_range(0, 9) == 0) s = "-";
        s = {s, rand_digits($urandom_range(0, int_max))};
        if ($urandom_range(0, 3) != 0) s = {s, ".", rand_digits($urandom_range(0, frac_max))};
        if ($urandom_range(0, 19) == 0) s = {s, ".", rand_digits(2)};
        return s;
    endfunction

    function automatic string rand_field(input int f);
        if ($urandom_range(0, 9) == 0) return "";
        case (f)
            ggap_pkg::FLD_TIME:  return $sformatf("%02d%02d%02d.%0d", $urandom_range(0, 23),
                                        $urandom_range(0, 59), $urandom_range(0, 59),
                                        $urandom_range(0, 999));
            ggap_pkg::FLD_LAT:   return $sformatf("%02d%02d.%05d", $urandom_range(0, 99),
                                        $urandom_range(0, 59), $urandom_range(0, 99999));
            ggap_pkg::FLD_LON:   return $sformatf("%03d%02d.%05d", $urandom_range(0, 199),
                                        $urandom_range(0, 59), $urandom_range(0, 99999));
            ggap_pkg::FLD_NS:    return ($urandom_range(0, 1) != 0) ? "S" : "N";
            ggap_pkg::FLD_EW:    return ($urandom_range(0, 1) != 0) ? "W" : "E";
            ggap_pkg::FLD_FIX:   return rand_digits($urandom_range(1, 2));
            ggap_pkg::FLD_SATS:  return rand_digits($urandom_range(1, 3));
            10, 12:              return "M";
            default:             return rand_number(8, 4);
        endcase
    endfunction

    task automatic send_random_sentence();
        string s;
        int nfields;
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)      s = "$GPGSA";
        else if (k == 1) s = "$GPGG";
        else if (k == 2) s = "$GPGGAX";
        else             s = "$GPGGA";
        nfields = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : 14;
        for (int f = 1; f <= nfields; f++) s = {s, ",", rand_field(f)};
        if ($urandom_range(0, 9) == 0) s = {s, ",", rand_digits(3), ",x"};
        k = $urandom_range(0, 3);
        if (k == 0)      s = {s, "\r\n"};
        else if (k == 1) s = {s, "\n"};
        else             s = {s, $sformatf("*%02X\r\n", $urandom_range(0, 255))};
        send_text(s);
    endtask

    // Garbage words, also covering the upper half of the byte range
    task automatic send_noise(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            if (c == ggap_pkg::CH_DOLLAR) c = 8'hA4;
            send_char(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_text("$GPGGA,235959.999,8959.99999,S,17959.99999,W,8,99,99.99,-99999.99,M,");
        send_text("99999.99,M,999.99,1023*00\r\n");
        send_text("$GPGGA,999999.9999,9999.999999,N,99999.9,E,15,255,123456,");
        send_text("123456789.99,M,-99999999,M,99999999,99999*7F\r\n");
        send_text("$GPGGA,,,,,,,,,,,,,,\r\n");
        send_text("$GPGGA,000000.000,0000.00000,N,00000.00000,E,0,00,0.0,0.0,M,0.0,M,,0000\n");
        send_text("$GPGGA,1,4807.038*");
        send_text("$GPGGA,123519,4807.038,\n");
        send_text("$GPGGA,1.2.3,4807.0381234,N,01131.000,W,1,7,0.9,545.4,M,46.9,M,,,9,9\r");
        send_text("$GPGGA,123,99999999999999999999,S\r\n");
        send_text("$GPGGA*");
        send_text("$GPGSA,A,3,04,05*6E\r\n");
        send_text("$GPGG,1,2\r\n$GPGGAA,1\r\n$gpgga,1\r\n");
        send_text("$GPGGA,12$GPGGA,1,2x3,N,-5,E,3-\r\n");
        send_text("outside$");
        send_text("\n");
        send_noise(16);
        send_text("\n");
    endtask

    task automatic test_random(input int n_words, input int tx_pct, input int rx_pct);
        int target;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 12));
            else send_random_sentence();
        end
    endtask

    // Long receiver hold while sentences keep arriving
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        for (int i = 0; i < 3; i++) send_random_sentence();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200, 0, 0);
        test_random(200, 64, 0);
        test_random(200, 0, 64);
        test_random(200, 19, 19);
        test_backpressure();
        test_random(50, 0, 0);
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_records.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Sent %0d character words, checked %0d GGA records", words_sent, records_seen);
        $display("Directed edge cases, random sentences and noise, four idle mixes, long hold");
        if (errors == 0 && pending_records.size() == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
